>>> hdl/baro_temp_press_compensation_assert.svh
// Assertion macros used by the compensation block top level
`ifndef BARO_TEMP_PRESS_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESS_COMPENSATION_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BTPC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define BTPC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/btpc_pkg.sv
// Package: widths, register codes and side-band type of the compensation block
`timescale 1ns / 1ps
package btpc_pkg;

	localparam int RawW   = 20;
	localparam int TrimW  = 48;
	localparam int TempW  = 23;
	localparam int FineW  = 24;
	localparam int PressW = 32;
	localparam int IdxW   = 2;
	localparam int NumW   = 64;
	localparam int DenW   = 31;

	// register indexes of the configuration port
	localparam logic [IdxW-1:0] RegTempTrim = 2'd0;
	localparam logic [IdxW-1:0] RegPressA   = 2'd1;
	localparam logic [IdxW-1:0] RegPressB   = 2'd2;
	localparam logic [IdxW-1:0] RegPressC   = 2'd3;

	localparam int unsigned FineOffset = 128000;
	localparam int unsigned PressBase  = 1048576;
	localparam int unsigned NumScale   = 3125;
	localparam int unsigned CentiRound = 128;

	// results that ride along the divider pipeline
	typedef struct packed {
		logic signed [TempW-1:0] tcenti;
		logic signed [FineW-1:0] tfine;
		logic                    neg;
		logic                    zero;
	} btpc_side_t;

endpackage

>>> hdl/btpc_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module btpc_div_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [btpc_pkg::NumW-1:0]     num,
	input  logic [btpc_pkg::DenW-1:0]     den,
	input  btpc_pkg::btpc_side_t          side_in,
	output logic                          out_valid,
	output logic [btpc_pkg::NumW-1:0]     quo,
	output btpc_pkg::btpc_side_t          side_out
);
	import btpc_pkg::*;

	logic            valid_s [NumW];
	logic [DenW-1:0] rem_s   [NumW];
	logic [NumW-1:0] dq_s    [NumW];
	logic [DenW-1:0] den_s   [NumW];
	btpc_side_t      side_s  [NumW];

	for (genvar k = 0; k < NumW; k++) begin : g_stage
		logic            v_in;
		logic [DenW-1:0] rem_in;
		logic [NumW-1:0] dq_in;
		logic [DenW-1:0] den_in;
		btpc_side_t      sd_in;
		logic [DenW:0]   trial;
		logic [DenW:0]   diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = '0;
			assign dq_in  = num;
			assign den_in = den;
			assign sd_in  = side_in;
		end else begin : g_next
			assign v_in   = valid_s[k-1];
			assign rem_in = rem_s[k-1];
			assign dq_in  = dq_s[k-1];
			assign den_in = den_s[k-1];
			assign sd_in  = side_s[k-1];
		end

		// shift in next dividend bit, subtract when it fits
		assign trial = {rem_in, dq_in[NumW-1]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
				dq_s[k]   <= {dq_in[NumW-2:0], ge};
				den_s[k]  <= den_in;
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = valid_s[NumW-1];
	assign quo       = dq_s[NumW-1];
	assign side_out  = side_s[NumW-1];

endmodule

>>> hdl/baro_temp_press_compensation.sv
// Top level: barometric temperature and pressure compensation pipeline
// Throughput: one sample pair per cycle while the output is not stalled;
// the 64-stage bit-per-stage divider sets the depth.
// A stalled output freezes the whole pipeline; input stall is high exactly then.
// Reset (arst_n low): all valid bits and trim registers clear to zero at once.
`timescale 1ns / 1ps
`include "baro_temp_press_compensation_assert.svh"
module baro_temp_press_compensation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [btpc_pkg::IdxW-1:0]           cfg_index,
	input  logic [btpc_pkg::TrimW-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [btpc_pkg::RawW-1:0]           raw_pressure,
	input  logic [btpc_pkg::RawW-1:0]           raw_temperature,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [btpc_pkg::TempW-1:0]   temperature_centi,
	output logic signed [btpc_pkg::FineW-1:0]   fine_temperature,
	output logic [btpc_pkg::PressW-1:0]         pressure_q24_8,
	output logic                                divisor_zero
);
	import btpc_pkg::*;

	// trim registers
	logic [TrimW-1:0] temp_trim_q, press_a_q, press_b_q, press_c_q;
	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0]        p8e, p9e;

	logic adv;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_f1, v_f2, v_f3, v_f4, v_f5, v_f6;
	logic dv;

	// temperature stages
	logic [RawW-1:0]    rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8;
	logic signed [17:0] d1_s1;
	logic signed [16:0] d2_s1;
	logic signed [33:0] m1_s2;
	logic [31:0]        dd_s2;
	logic signed [22:0] tv1_s3;
	logic signed [36:0] m2_s3;
	logic signed [FineW-1:0] tf_s4;
	logic signed [24:0] x_s5;
	btpc_side_t side_s5, side_s6, side_s7, side_s8, side_s9, side_s10, side_s11;

	// pressure stages before the divider
	logic [46:0]        xx_s6;
	logic signed [40:0] xp5_s6, xp2_s6, xp5_s7, xp2_s7;
	logic [63:0]        b1_s7, a1_s7, b_s8, a_s8, ap_s9, num1_s9, num_s10;
	logic [DenW-1:0]    den_s10;
	logic [NumW-1:0]    mnum_s11;
	logic [DenW-1:0]    mden_s11;

	// stages after the divider
	logic [NumW-1:0]    quo;
	btpc_side_t         dside, side_f1, side_f2, side_f3, side_f4, side_f5, side_f6;
	logic [63:0]        p_f1;
	logic [39:0]        p_f2, p_f3, p_f4, p_f5;
	logic [63:0]        mll_f2;
	logic [30:0]        mhl_f2;
	logic signed [48:0] pl8_f2;
	logic [31:0]        ph8_f2;
	logic [63:0]        qq_f3;
	logic [39:0]        c2_f3, c2_f4, c2_f5;
	logic signed [48:0] ql9_f4;
	logic [31:0]        qh9_f4;
	logic [39:0]        c1_f5;
	logic [39:0]        s_f6;

	// combinational terms
	logic signed [17:0] d1_c;
	logic signed [16:0] d2_c;
	logic signed [33:0] m1_c, dd_c;
	logic signed [36:0] m2_c;
	logic [FineW-1:0]   tf_c;
	logic [24:0]        x_c;
	logic [27:0]        t5_c;
	logic signed [49:0] xx_c;
	logic signed [40:0] xp5_c, xp2_c;
	logic signed [63:0] b1_c, a1_c;
	logic [63:0]        b_c, a_c;
	logic [20:0]        pp_c;
	logic signed [73:0] am_c;
	logic [63:0]        num_c;
	logic [63:0]        q_c, mll_c, mhl_c, ph8_c, qq_c, c2full_c, qh9_c, prod_c;
	logic signed [48:0] pl8_c, ql9_c;
	logic [39:0]        s_c;
	logic [31:0]        res_c;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q <= '0;
			press_a_q   <= '0;
			press_b_q   <= '0;
			press_c_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegTempTrim: temp_trim_q <= cfg_data;
				RegPressA:   press_a_q   <= cfg_data;
				RegPressB:   press_b_q   <= cfg_data;
				RegPressC:   press_c_q   <= cfg_data;
				default:     temp_trim_q <= temp_trim_q;
			endcase
		end
	end

	// trim word fields
	assign t1  = temp_trim_q[15:0];
	assign t2  = temp_trim_q[31:16];
	assign t3  = temp_trim_q[47:32];
	assign p1  = press_a_q[15:0];
	assign p2  = press_a_q[31:16];
	assign p3  = press_a_q[47:32];
	assign p4  = press_b_q[15:0];
	assign p5  = press_b_q[31:16];
	assign p6  = press_b_q[47:32];
	assign p7  = press_c_q[15:0];
	assign p8  = press_c_q[31:16];
	assign p9  = press_c_q[47:32];
	assign p8e = {{16{p8[15]}}, p8};
	assign p9e = {{16{p9[15]}}, p9};

	// whole pipeline moves unless the output holds a stalled result
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// temperature terms
	assign d1_c  = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign d2_c  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
	assign m1_c  = d1_s1 * t2;
	assign dd_c  = d2_s1 * d2_s1;
	assign m2_c  = $signed({1'b0, dd_s2[31:12]}) * t3;
	assign tf_c  = {tv1_s3[22], tv1_s3} + {m2_s3[36], m2_s3[36:14]};
	assign x_c   = {tf_s4[23], tf_s4} - 25'(FineOffset);
	assign t5_c  = {{4{tf_s4[23]}}, tf_s4} + {{2{tf_s4[23]}}, tf_s4, 2'b00} + 28'(CentiRound);

	// pressure numerator and divisor
	assign xx_c  = x_s5 * x_s5;
	assign xp5_c = x_s5 * p5;
	assign xp2_c = x_s5 * p2;
	assign b1_c  = $signed({1'b0, xx_s6}) * p6;
	assign a1_c  = $signed({1'b0, xx_s6}) * p3;
	assign b_c   = b1_s7 + {{6{xp5_s7[40]}}, xp5_s7, 17'b0} + {{13{p4[15]}}, p4, 35'b0};
	assign a_c   = {{8{a1_s7[63]}}, a1_s7[63:8]} + {{11{xp2_s7[40]}}, xp2_s7, 12'b0};
	assign pp_c  = 21'(PressBase) - {1'b0, rp_s8};
	assign am_c  = $signed(ap_s9[56:0]) * $signed({1'b0, p1});
	assign num_c = num1_s9 * 64'(NumScale);

	// correction terms after the divider (64-bit terms wrap mod 2^64)
	assign q_c      = {{13{p_f1[63]}}, p_f1[63:13]};
	assign mll_c    = {32'b0, q_c[31:0]} * {32'b0, q_c[31:0]};
	assign mhl_c    = {32'b0, q_c[63:32]} * {32'b0, q_c[31:0]};
	assign pl8_c    = $signed({1'b0, p_f1[31:0]}) * p8;
	assign ph8_c    = {32'b0, p_f1[63:32]} * {32'b0, p8e};
	assign qq_c     = mll_f2 + {mhl_f2, 33'b0};
	assign c2full_c = {{15{pl8_f2[48]}}, pl8_f2} + {ph8_f2, 32'b0};
	assign ql9_c    = $signed({1'b0, qq_f3[31:0]}) * p9;
	assign qh9_c    = {32'b0, qq_f3[63:32]} * {32'b0, p9e};
	assign prod_c   = {{15{ql9_f4[48]}}, ql9_f4} + {qh9_f4, 32'b0};
	assign s_c      = p_f5 + c1_f5 + c2_f5;
	assign res_c    = s_f6[39:8] + {{12{p7[15]}}, p7, 4'b0};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
			v_f1 <= 1'b0; v_f2 <= 1'b0; v_f3 <= 1'b0; v_f4 <= 1'b0;
			v_f5 <= 1'b0; v_f6 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s9 <= v_s8; v_s10 <= v_s9; v_s11 <= v_s10;
			v_f1 <= dv; v_f2 <= v_f1; v_f3 <= v_f2; v_f4 <= v_f3;
			v_f5 <= v_f4; v_f6 <= v_f5;
			out_valid <= v_f6;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// input and first differences
			rp_s1 <= raw_pressure;
			d1_s1 <= d1_c;
			d2_s1 <= d2_c;
			// temperature products
			rp_s2 <= rp_s1;
			m1_s2 <= m1_c;
			dd_s2 <= dd_c[31:0];
			rp_s3 <= rp_s2;
			tv1_s3 <= m1_s2[33:11];
			m2_s3 <= m2_c;
			// fine temperature
			rp_s4 <= rp_s3;
			tf_s4 <= tf_c;
			// centi-degrees and pressure offset
			rp_s5 <= rp_s4;
			x_s5 <= x_c;
			side_s5.tcenti <= {{3{t5_c[27]}}, t5_c[27:8]};
			side_s5.tfine  <= tf_s4;
			side_s5.neg    <= 1'b0;
			side_s5.zero   <= 1'b0;
			// squares and linear terms
			rp_s6 <= rp_s5;
			side_s6 <= side_s5;
			xx_s6 <= xx_c[46:0];
			xp5_s6 <= xp5_c;
			xp2_s6 <= xp2_c;
			rp_s7 <= rp_s6;
			side_s7 <= side_s6;
			b1_s7 <= b1_c;
			a1_s7 <= a1_c;
			xp5_s7 <= xp5_s6;
			xp2_s7 <= xp2_s6;
			// numerator offset and divisor terms
			rp_s8 <= rp_s7;
			side_s8 <= side_s7;
			b_s8 <= b_c;
			a_s8 <= a_c;
			side_s9 <= side_s8;
			ap_s9 <= a_s8 + {16'b0, 1'b1, 47'b0};
			num1_s9 <= {12'b0, pp_c, 31'b0} - b_s8;
			side_s10 <= side_s9;
			den_s10 <= am_c[63:33];
			num_s10 <= num_c;
			// signs and magnitudes for the divider
			side_s11.tcenti <= side_s10.tcenti;
			side_s11.tfine  <= side_s10.tfine;
			side_s11.neg    <= num_s10[63] ^ den_s10[DenW-1];
			side_s11.zero   <= (den_s10 == '0);
			mnum_s11 <= num_s10[63] ? (64'd0 - num_s10) : num_s10;
			mden_s11 <= den_s10[DenW-1] ? (31'd0 - den_s10) : den_s10;
			// signed quotient
			side_f1 <= dside;
			p_f1 <= dside.neg ? (64'd0 - quo) : quo;
			// partial products of q*q and p8*p
			side_f2 <= side_f1;
			p_f2 <= p_f1[39:0];
			mll_f2 <= mll_c;
			mhl_f2 <= mhl_c[30:0];
			pl8_f2 <= pl8_c;
			ph8_f2 <= ph8_c[31:0];
			side_f3 <= side_f2;
			p_f3 <= p_f2;
			qq_f3 <= qq_c;
			c2_f3 <= c2full_c[58:19];
			// partial products of p9*q*q
			side_f4 <= side_f3;
			p_f4 <= p_f3;
			c2_f4 <= c2_f3;
			ql9_f4 <= ql9_c;
			qh9_f4 <= qh9_c[31:0];
			side_f5 <= side_f4;
			p_f5 <= p_f4;
			c2_f5 <= c2_f4;
			c1_f5 <= {prod_c[63], prod_c[63:25]};
			side_f6 <= side_f5;
			s_f6 <= s_c;
			// output register
			temperature_centi <= side_f6.tcenti;
			fine_temperature  <= side_f6.tfine;
			divisor_zero      <= side_f6.zero;
			pressure_q24_8    <= side_f6.zero ? '0 : res_c;
		end
	end

	btpc_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s11),
		.num       (mnum_s11),
		.den       (mden_s11),
		.side_in   (side_s11),
		.out_valid (dv),
		.quo       (quo),
		.side_out  (dside)
	);

	`BTPC_ASSERT_IMP(a_stall_ctl, clk, arst_n, 1'b1, in_stall == (out_valid && out_stall), "input stall does not track output hold")
	`BTPC_ASSERT_IMP(a_zero_press, clk, arst_n, out_valid && divisor_zero, pressure_q24_8 == '0, "zero divisor with nonzero pressure")
	`BTPC_ASSERT_NXT(a_drain, clk, arst_n, out_valid && !out_stall && !v_f6, !out_valid, "result repeated after transfer")

endmodule

>>> bench/btpc_checker.sv
// Checker: watches both channels, predicts compensation results and compares them
`timescale 1ns / 1ps
module btpc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [btpc_pkg::IdxW-1:0]          cfg_index,
	input  logic [btpc_pkg::TrimW-1:0]         cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [btpc_pkg::RawW-1:0]          raw_pressure,
	input  logic [btpc_pkg::RawW-1:0]          raw_temperature,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [btpc_pkg::TempW-1:0]  temperature_centi,
	input  logic signed [btpc_pkg::FineW-1:0]  fine_temperature,
	input  logic [btpc_pkg::PressW-1:0]        pressure_q24_8,
	input  logic                               divisor_zero,
	output int                                 fail_count,
	output int                                 pending_count
);
	import btpc_pkg::*;

	typedef struct packed {
		logic signed [TempW-1:0] tcenti;
		logic signed [FineW-1:0] tfine;
		logic [PressW-1:0]       press;
		logic                    zero;
	} comp_result_t;

	logic [TrimW-1:0] temp_trim, press_a, press_b, press_c;
	comp_result_t compensated_q[$];

	// signed 16-bit word of a trim register
	function automatic longint trim_word(logic [TrimW-1:0] r, int pos);
		logic signed [15:0] w;
		w = r[pos +: 16];
		return longint'(w);
	endfunction

	// integer compensation, 64-bit wrapping arithmetic
	function automatic comp_result_t compensate(logic [RawW-1:0] rp, logic [RawW-1:0] rt);
		comp_result_t r;
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint d1, d2, tfine, tc, x, b, a, p, q, c1, c2, num;
		t1 = longint'(temp_trim[15:0]);
		t2 = trim_word(temp_trim, 16);
		t3 = trim_word(temp_trim, 32);
		p1 = longint'(press_a[15:0]);
		p2 = trim_word(press_a, 16);
		p3 = trim_word(press_a, 32);
		p4 = trim_word(press_b, 0);
		p5 = trim_word(press_b, 16);
		p6 = trim_word(press_b, 32);
		p7 = trim_word(press_c, 0);
		p8 = trim_word(press_c, 16);
		p9 = trim_word(press_c, 32);
		// temperature
		d1 = longint'(rt >> 3) - (t1 << 1);
		d2 = longint'(rt >> 4) - t1;
		tfine = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
		tc = (tfine * 5 + 128) >>> 8;
		r.tcenti = tc[TempW-1:0];
		r.tfine = tfine[FineW-1:0];
		// pressure
		x = tfine - 128000;
		b = x * x * p6;
		b = b + ((x * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
		a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
		if (a == 0) begin
			r.press = '0;
			r.zero = 1'b1;
		end else begin
			p = 1048576 - longint'(rp);
			num = ((p <<< 31) - b) * 3125;
			if (num == 64'sh8000000000000000 && a == -1)
				p = num;
			else
				p = num / a;
			q = p >>> 13;
			c1 = (p9 * q * q) >>> 25;
			c2 = (p8 * p) >>> 19;
			p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
			r.press = p[31:0];
			r.zero = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	// trim registers, predictions and result comparison
	always @(posedge clk or negedge arst_n) begin
		comp_result_t want;
		if (!arst_n) begin
			temp_trim <= '0;
			press_a <= '0;
			press_b <= '0;
			press_c <= '0;
			compensated_q.delete();
			pending_count = 0;
		end else begin
			if (in_valid && !in_stall)
				compensated_q.push_back(compensate(raw_pressure, raw_temperature));
			if (out_valid && !out_stall) begin
				if (compensated_q.size() == 0) begin
					report_mismatch("unexpected result transfer, pending", 0, 1);
				end else begin
					want = compensated_q.pop_front();
					if (temperature_centi !== want.tcenti)
						report_mismatch("temperature_centi", temperature_centi, want.tcenti);
					if (fine_temperature !== want.tfine)
						report_mismatch("fine_temperature", fine_temperature, want.tfine);
					if (pressure_q24_8 !== want.press)
						report_mismatch("pressure_q24_8", pressure_q24_8, want.press);
					if (divisor_zero !== want.zero)
						report_mismatch("divisor_zero", divisor_zero, want.zero);
				end
			end
			pending_count = compensated_q.size();
			if (cfg_we) begin
				case (cfg_index)
					RegTempTrim: temp_trim <= cfg_data;
					RegPressA: press_a <= cfg_data;
					RegPressB: press_b <= cfg_data;
					RegPressC: press_c <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

>>> bench/tb_baro_temp_press_compensation.sv
// Testbench top: stimulus, configuration phases and final verdict
`timescale 1ns / 1ps
module tb_baro_temp_press_compensation;
	import btpc_pkg::*;

	localparam int Latency = 82;
	localparam longint CycleLimit = 400000;

	logic clk, arst_n, cfg_we, in_valid, in_stall, out_valid, out_stall, divisor_zero;
	logic [IdxW-1:0] cfg_index;
	logic [TrimW-1:0] cfg_data;
	logic [RawW-1:0] raw_pressure, raw_temperature;
	logic signed [TempW-1:0] temperature_centi;
	logic signed [FineW-1:0] fine_temperature;
	logic [PressW-1:0] pressure_q24_8;
	int fail_count, pending_count;
	longint cycle_count;
	bit slow_sink;
	int sink_wait;

	baro_temp_press_compensation i_dut (.*);
	btpc_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("baro_temp_press_compensation test failed");
			$finish;
		end
	end

	// receiver stalls: a fresh wait is drawn after each result transfer
	initial begin
		out_stall = 1'b0;
		sink_wait = 0;
	end
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sink_wait = $urandom_range(0, 18);
	end
	always @(negedge clk) begin
		if (slow_sink && out_valid && sink_wait > 0) begin
			out_stall <= 1'b1;
			sink_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_pair(logic [RawW-1:0] rp, logic [RawW-1:0] rt, bit gaps);
		int wait_cycles;
		wait_cycles = gaps ? $urandom_range(0, 18) : 0;
		if (wait_cycles != 0) begin
			in_valid <= 1'b0;
			repeat (wait_cycles) @(negedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= rp;
		raw_temperature <= rt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (Latency + 10) @(negedge clk);
	endtask

	task automatic write_trim(logic [IdxW-1:0] idx, logic [TrimW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// realistic trim set with random spread
	task automatic load_typical;
		logic [15:0] w[12];
		w = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
			16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
		foreach (w[i]) w[i] = 16'(w[i] + $urandom_range(0, 63) - 32);
		write_trim(RegTempTrim, {w[2], w[1], w[0]});
		write_trim(RegPressA, {w[5], w[4], w[3]});
		write_trim(RegPressB, {w[8], w[7], w[6]});
		write_trim(RegPressC, {w[11], w[10], w[9]});
	endtask

	task automatic load_random;
		write_trim(RegTempTrim, 48'({$urandom, $urandom}));
		write_trim(RegPressA, 48'({$urandom, $urandom}));
		write_trim(RegPressB, 48'({$urandom, $urandom}));
		write_trim(RegPressC, 48'({$urandom, $urandom}));
	endtask

	task automatic load_all(logic [TrimW-1:0] val);
		write_trim(RegTempTrim, val);
		write_trim(RegPressA, val);
		write_trim(RegPressB, val);
		write_trim(RegPressC, val);
	endtask

	task automatic random_burst(int count, bit gaps);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0)
				send_pair(20'($urandom), 20'($urandom), gaps);
			else
				send_pair(20'(300000 + $urandom_range(0, 400000)),
					20'(420000 + $urandom_range(0, 200000)), gaps);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = RegTempTrim;
		cfg_data = '0;
		in_valid = 1'b0;
		raw_pressure = '0;
		raw_temperature = '0;
		slow_sink = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset trims give a zero divisor
		send_pair('0, '0, 1'b0);
		send_pair('1, '1, 1'b0);
		drain();
		// all-ones, then most-negative and most-positive upper words over an all-ones low word
		load_all('1);
		send_pair('0, '1, 1'b0);
		send_pair('1, '0, 1'b0);
		drain();
		load_all(48'h8000_8000_FFFF);
		send_pair('0, '1, 1'b0);
		send_pair('1, '1, 1'b0);
		send_pair(20'h55555, 20'hAAAAA, 1'b0);
		drain();
		load_all(48'h7FFF_7FFF_FFFF);
		send_pair('0, '0, 1'b0);
		send_pair('1, '1, 1'b0);
		send_pair(20'hAAAAA, 20'h55555, 1'b0);
		drain();
		load_typical();
		send_pair(20'd415148, 20'd519888, 1'b0);
		send_pair('0, 20'd519888, 1'b0);
		send_pair('1, 20'd519888, 1'b0);
		send_pair(20'd415148, '0, 1'b0);
		send_pair(20'd415148, '1, 1'b0);
		drain();

		// random phases over several trim settings
		for (int ph = 0; ph < 8; ph++) begin
			slow_sink = (ph % 3 != 2);
			if (ph % 2 == 0) load_typical();
			else load_random();
			random_burst(70, 1'b1);
			random_burst(40, 1'b0);
			// pause until everything is back, then continue
			in_valid <= 1'b0;
			while (pending_count != 0) @(negedge clk);
			random_burst(30, ph % 2 == 1);
			drain();
		end

		if (fail_count == 0)
			$display("baro_temp_press_compensation test passed");
		else
			$display("baro_temp_press_compensation test failed");
		$finish;
	end
endmodule

>>> sim.f
+incdir+hdl
hdl/btpc_pkg.sv
hdl/btpc_div_pipe.sv
hdl/baro_temp_press_compensation.sv
bench/btpc_checker.sv
bench/tb_baro_temp_press_compensation.sv
